@@ src/clamped_pid_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the clamped PID controller
// Shorthands for clocked implication checks with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_PID_CONTROLLER_TOP_MACROS_SVH
`define CLAMPED_PID_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define CPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpid check failed");

// next-cycle implication
`define CPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpid check failed");

`endif

@@ src/cpid_pkg.sv @@
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SP_W             = 16;
  localparam int GAIN_W           = 16;
  localparam int LIM_W            = 15;
  localparam int DRIVE_W          = 16;
  localparam int LERR_W           = 17;   // error width inside the linear region
  localparam int SUM_W            = 22;
  localparam int SUM_LIMIT        = 1500000;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    REGION_HOLD = 2'd0,
    REGION_HIGH = 2'd1,
    REGION_LOW  = 2'd2,
    REGION_PID  = 2'd3
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_POINT   = 3'd0,
    CFG_DEAD_BAND   = 3'd1,
    CFG_BANG_LIMIT  = 3'd2,
    CFG_DRIVE_LIMIT = 3'd3,
    CFG_GAIN_P      = 3'd4,
    CFG_GAIN_I      = 3'd5,
    CFG_GAIN_D      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SP_W-1:0] set_point;
    logic [15:0]            dead_band;
    logic [15:0]            bang_limit;
    logic [LIM_W-1:0]       drive_limit;
    logic [GAIN_W-1:0]      gain_p;
    logic [GAIN_W-1:0]      gain_i;
    logic [GAIN_W-1:0]      gain_d;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    set_point:   16'sd0,
    dead_band:   16'd0,
    bang_limit:  16'hFFFF,
    drive_limit: 15'h7FFF,
    gain_p:      16'd256,
    gain_i:      16'd0,
    gain_d:      16'd0
  };

  // classified item handed from front to back
  typedef struct packed {
    region_e                  region;
    logic signed [LERR_W-1:0] err;
  } cmd_t;

endpackage

@@ src/cpid_if.sv @@
// ----------------------------------------------------------------------------
// cpid channel interfaces
// Valid/ready channels for samples in and drive results out.
// ----------------------------------------------------------------------------
interface cpid_in_if #(
  parameter int SAMPLE_WIDTH = cpid_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measured;

  modport source (output valid, output measured, input ready);
  modport sink   (input valid, input measured, output ready);
endinterface

interface cpid_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cpid_pkg::DRIVE_W-1:0]   drive;
  logic [1:0]                            region;

  modport source (output valid, output drive, output region, input ready);
  modport sink   (input valid, input drive, input region, output ready);
endinterface

@@ src/cpid_front.sv @@
// ----------------------------------------------------------------------------
// cpid_front
// Accepts samples, forms the error and classifies it into a region.
// ----------------------------------------------------------------------------
module cpid_front #(
  parameter int SAMPLE_WIDTH = cpid_pkg::SAMPLE_WIDTH_DEF
) (
  input  cpid_pkg::cfg_t  cfg_i,
  cpid_in_if.sink         in_i,
  input  logic            q_ready_i,
  output logic            push_o,
  output cpid_pkg::cmd_t  cmd_o
);
  import cpid_pkg::*;

  localparam int ERR_W = ((SAMPLE_WIDTH > SP_W) ? SAMPLE_WIDTH : SP_W) + 1;
  localparam int CMP_W = ERR_W + 1;

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        mag;
  logic signed [CMP_W-1:0] err_x;
  logic signed [CMP_W-1:0] bang_x;
  logic                    in_band;

  assign err    = ERR_W'($signed(cfg_i.set_point)) - ERR_W'(in_i.measured);
  assign mag    = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign in_band = mag < ERR_W'(cfg_i.dead_band);
  assign err_x  = CMP_W'(err);
  assign bang_x = CMP_W'(cfg_i.bang_limit);

  always_comb begin
    // only meaningful in the linear region, where |err| <= bang_limit
    cmd_o.err = err[LERR_W-1:0];
    priority if (in_band) begin
      cmd_o.region = REGION_HOLD;
    end else if (err_x > bang_x) begin
      cmd_o.region = REGION_HIGH;
    end else if (err_x < -bang_x) begin
      cmd_o.region = REGION_LOW;
    end else begin
      cmd_o.region = REGION_PID;
    end
  end

  assign in_i.ready = q_ready_i;
  assign push_o     = in_i.valid && q_ready_i;

endmodule

@@ src/cpid_queue.sv @@
// ----------------------------------------------------------------------------
// cpid_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module cpid_queue #(
  parameter int DEPTH = cpid_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cpid_pkg::cmd_t cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cpid_pkg::cmd_t cmd_o
);
  import cpid_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = cnt_q != CNT_W'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ src/cpid_back.sv @@
// ----------------------------------------------------------------------------
// cpid_back
// Integral/derivative update, gain multiplies, sum and clamp, result register.
// ----------------------------------------------------------------------------
module cpid_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cpid_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  cpid_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  cpid_out_if.source     out_o
);
  import cpid_pkg::*;

  localparam int DER_W = LERR_W + 1;
  localparam int SG_W  = GAIN_W + 1;
  localparam int PP_W  = LERR_W + SG_W;
  localparam int PI_W  = SUM_W + SG_W;
  localparam int PD_W  = DER_W + SG_W;
  localparam int TOT_W = PI_W - 8 + 2;

  // state
  logic signed [SUM_W-1:0]  err_sum_q, err_sum_d;
  logic signed [LERR_W-1:0] last_err_q;

  // stage 1: operands
  logic                     s1_v_q;
  region_e                  s1_region_q;
  logic signed [LERR_W-1:0] s1_err_q;
  logic signed [SUM_W-1:0]  s1_sum_q;
  logic signed [DER_W-1:0]  s1_der_q;

  // stage 2: products
  logic                     s2_v_q;
  region_e                  s2_region_q;
  logic signed [PP_W-1:0]   s2_pp_q;
  logic signed [PI_W-1:0]   s2_pi_q;
  logic signed [PD_W-1:0]   s2_pd_q;

  // result register; drive_q doubles as the held drive
  logic                     out_v_q;
  logic signed [DRIVE_W-1:0] drive_q, drive_d;
  region_e                  region_q;

  logic                     adv;
  logic                     take_pid;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [DER_W-1:0]  der;
  logic signed [SG_W-1:0]   gp_s, gi_s, gd_s;
  logic signed [PP_W-1:0]   pp, pp_adj;
  logic signed [PI_W-1:0]   pi, pi_adj;
  logic signed [PD_W-1:0]   pd, pd_adj;
  logic signed [TOT_W-1:0]  total, lim_x;
  logic signed [DRIVE_W-1:0] lim16;

  assign adv      = !out_v_q || out_o.ready;
  assign q_pop_o  = adv && q_valid_i;
  assign take_pid = q_pop_o && (q_cmd_i.region == REGION_PID);

  // integral with anti-windup
  assign sum_ext = (SUM_W + 1)'(err_sum_q) + (SUM_W + 1)'(q_cmd_i.err);
  always_comb begin
    priority if (sum_ext > (SUM_W + 1)'(SUM_LIMIT)) begin
      err_sum_d = SUM_W'(SUM_LIMIT);
    end else if (sum_ext < (SUM_W + 1)'(-SUM_LIMIT)) begin
      err_sum_d = SUM_W'(-SUM_LIMIT);
    end else begin
      err_sum_d = sum_ext[SUM_W-1:0];
    end
  end
  assign der = DER_W'(q_cmd_i.err) - DER_W'(last_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_q  <= '0;
      last_err_q <= '0;
    end else if (take_pid) begin
      err_sum_q  <= err_sum_d;
      last_err_q <= q_cmd_i.err;
    end
  end

  assign gp_s = SG_W'(cfg_i.gain_p);
  assign gi_s = SG_W'(cfg_i.gain_i);
  assign gd_s = SG_W'(cfg_i.gain_d);
  assign pp   = gp_s * s1_err_q;
  assign pi   = gi_s * s1_sum_q;
  assign pd   = gd_s * s1_der_q;

  // divide by 256 truncating toward zero
  assign pp_adj = s2_pp_q + (s2_pp_q[PP_W-1] ? PP_W'(255) : PP_W'(0));
  assign pi_adj = s2_pi_q + (s2_pi_q[PI_W-1] ? PI_W'(255) : PI_W'(0));
  assign pd_adj = s2_pd_q + (s2_pd_q[PD_W-1] ? PD_W'(255) : PD_W'(0));
  assign total  = TOT_W'($signed(pp_adj[PP_W-1:8]))
                + TOT_W'($signed(pi_adj[PI_W-1:8]))
                + TOT_W'($signed(pd_adj[PD_W-1:8]));
  assign lim_x  = TOT_W'(cfg_i.drive_limit);
  assign lim16  = DRIVE_W'(cfg_i.drive_limit);

  always_comb begin
    unique case (s2_region_q)
      REGION_HOLD: drive_d = drive_q;
      REGION_HIGH: drive_d = lim16;
      REGION_LOW:  drive_d = -lim16;
      REGION_PID: begin
        priority if (total > lim_x) begin
          drive_d = lim16;
        end else if (total < -lim_x) begin
          drive_d = -lim16;
        end else begin
          drive_d = total[DRIVE_W-1:0];
        end
      end
      default:     drive_d = drive_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      drive_q <= '0;
    end else if (adv) begin
      s1_v_q  <= q_valid_i;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
      if (s2_v_q) begin
        drive_q <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_region_q <= q_cmd_i.region;
      s1_err_q    <= q_cmd_i.err;
      s1_sum_q    <= err_sum_d;
      s1_der_q    <= der;
      s2_region_q <= s1_region_q;
      s2_pp_q     <= pp;
      s2_pi_q     <= pi;
      s2_pd_q     <= pd;
      region_q    <= s2_region_q;
    end
  end

  assign out_o.valid  = out_v_q;
  assign out_o.drive  = drive_q;
  assign out_o.region = region_q;

endmodule

@@ src/clamped_pid_controller_top.sv @@
// ----------------------------------------------------------------------------
// clamped_pid_controller_top
// Positional PID controller with dead band, bang-bang forcing and clamping.
//
//   channel   dir  payload                 accepted when
//   in_i      in   measured                valid && ready
//   out_o     out  drive, region           valid && ready
//   cfg       in   cfg_idx_i, cfg_data_i   cfg_we_i
//
// One item per cycle while out_o is not stalled; an accepted item passes
// through the queue, operand stage, multiply stage and result register.
// Integral and last error update in operand stage, one item per unstalled cycle.
// Reset loads the register defaults and clears integral, last error and drive.
// A stalled result freezes the back pipeline; the 2-entry queue then fills
// and in_i.ready drops.
// ----------------------------------------------------------------------------
module clamped_pid_controller_top #(
  parameter int SAMPLE_WIDTH = cpid_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [cpid_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  cpid_in_if.sink                            in_i,
  cpid_out_if.source                         out_o
);
  import cpid_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, q_cmd;
  logic push, q_ready, q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SET_POINT:   cfg_q.set_point   <= cfg_data_i;
        CFG_DEAD_BAND:   cfg_q.dead_band   <= cfg_data_i;
        CFG_BANG_LIMIT:  cfg_q.bang_limit  <= cfg_data_i;
        CFG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data_i[LIM_W-1:0];
        CFG_GAIN_P:      cfg_q.gain_p      <= cfg_data_i;
        CFG_GAIN_I:      cfg_q.gain_i      <= cfg_data_i;
        CFG_GAIN_D:      cfg_q.gain_d      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cpid_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .cfg_i     (cfg_q),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  cpid_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  cpid_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

@@ src/cpid_checker.sv @@
// ----------------------------------------------------------------------------
// cpid_checker
// Port-level checks on the result channel of the clamped PID controller.
// ----------------------------------------------------------------------------
`include "clamped_pid_controller_top_macros.svh"

module cpid_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [cpid_pkg::DRIVE_W-1:0] drive_i,
  input logic [1:0]                        region_i
);
  import cpid_pkg::*;

  logic signed [DRIVE_W-1:0] last_drv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_drv_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_drv_q <= drive_i;
    end
  end

  `CPID_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `CPID_ASSERT_IMP(a_hold_repeats, clk_i, rst_ni, out_valid_i && region_i == REGION_HOLD, drive_i == last_drv_q)
  `CPID_ASSERT_IMP(a_high_nonneg, clk_i, rst_ni, out_valid_i && region_i == REGION_HIGH, !drive_i[DRIVE_W-1])
  `CPID_ASSERT_IMP(a_low_nonpos, clk_i, rst_ni, out_valid_i && region_i == REGION_LOW, drive_i[DRIVE_W-1] || drive_i == '0)
  `CPID_ASSERT_IMP(a_drive_range, clk_i, rst_ni, out_valid_i, drive_i != 16'sh8000)

endmodule

bind clamped_pid_controller_top cpid_checker u_cpid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .drive_i     (out_o.drive),
  .region_i    (out_o.region)
);

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: clamped PID controller testbench
// Feeds measured samples under random bursts and stalls and tracks the PID
// state, dead band, forcing and clamping to predict every drive and region.
// Registers change between phases, only while the controller is idle.
// ----------------------------------------------------------------------------
module tb;
  import cpid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    region_e                   region;
  } drive_result_t;

  class pid_tracker;
    cfg_t                      cfg;
    logic signed [SUM_W-1:0]   integral;
    logic signed [LERR_W-1:0]  prev_err;
    logic signed [DRIVE_W-1:0] last_drive;
    drive_result_t             expected_q[$];
    int                        failures;

    function new();
      cfg        = CFG_RESET;
      integral   = '0;
      prev_err   = '0;
      last_drive = '0;
      failures   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SET_POINT:   cfg.set_point   = data;
        CFG_DEAD_BAND:   cfg.dead_band   = data;
        CFG_BANG_LIMIT:  cfg.bang_limit  = data;
        CFG_DRIVE_LIMIT: cfg.drive_limit = data[LIM_W-1:0];
        CFG_GAIN_P:      cfg.gain_p      = data;
        CFG_GAIN_I:      cfg.gain_i      = data;
        CFG_GAIN_D:      cfg.gain_d      = data;
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [15:0] meas);
      longint        err, mag, lim, acc, deriv, total;
      drive_result_t r;
      err = longint'($signed(cfg.set_point)) - longint'(meas);
      mag = (err < 0) ? -err : err;
      lim = longint'(cfg.drive_limit);
      if (mag < longint'(cfg.dead_band)) begin
        r.region = REGION_HOLD;
      end else if (err > longint'(cfg.bang_limit)) begin
        last_drive = DRIVE_W'(lim);
        r.region   = REGION_HIGH;
      end else if (-err > longint'(cfg.bang_limit)) begin
        last_drive = DRIVE_W'(-lim);
        r.region   = REGION_LOW;
      end else begin
        acc = longint'(integral) + err;
        if (acc > SUM_LIMIT) acc = SUM_LIMIT;
        if (acc < -SUM_LIMIT) acc = -SUM_LIMIT;
        integral = SUM_W'(acc);
        deriv    = err - longint'(prev_err);
        prev_err = LERR_W'(err);
        // Q8.8 terms, each truncated toward zero
        total = (longint'(cfg.gain_p) * err) / 256
              + (longint'(cfg.gain_i) * acc) / 256
              + (longint'(cfg.gain_d) * deriv) / 256;
        if (total > lim) total = lim;
        if (total < -lim) total = -lim;
        last_drive = DRIVE_W'(total);
        r.region   = REGION_PID;
      end
      r.drive = last_drive;
      expected_q.push_back(r);
    endfunction

    function void check_drive(logic signed [DRIVE_W-1:0] drive, logic [1:0] region);
      drive_result_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: drive %0d region %0d", drive, region);
        failures++;
        return;
      end
      r = expected_q.pop_front();
      if (drive !== r.drive) begin
        $error("drive: expected %0d, actual %0d", r.drive, drive);
        failures++;
      end
      if (region !== r.region) begin
        $error("region: expected %0d, actual %0d", r.region, region);
        failures++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cpid_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_if ();
  cpid_out_if                                   out_if ();

  clamped_pid_controller_top #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  pid_tracker tracker;
  int         burst_left = 0;
  int         cycles = 0;
  int         rx_count = 0;
  int         rx_mode = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (rx_count == 0) begin
      rx_mode  <= $urandom_range(0, 3);
      rx_count <= $urandom_range(20, 120);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ((rx_count % 16) < 6);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      tracker.check_drive(out_if.drive, out_if.region);
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic push_sample(input logic signed [15:0] meas);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid    <= 1'b0;
        in_if.measured <= 16'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid    <= 1'b1;
    in_if.measured <= meas;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.take_sample(meas);
  endtask

  // idle until every expected item is back, plus pipeline latency
  task automatic settle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd256;
      3: return 16'($urandom_range(0, 1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] near_set_point(int span);
    longint v;
    v = longint'($signed(tracker.cfg.set_point)) + $urandom_range(0, 2 * span) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  initial begin
    logic signed [15:0] pts_reset[] = '{16'sd0, -16'sd32768, 16'sd32767, 16'h5555, 16'hAAAA};
    logic signed [15:0] pts_band[]  = '{16'sd0, 16'sd99, -16'sd99, 16'sd100, -16'sd100,
                                        16'sd1000, -16'sd1000, 16'sd1001, -16'sd1001,
                                        16'sd50};
    logic signed [15:0] pts_zero[]  = '{-16'sd32768, 16'sd32767, 16'sd0};
    int                 kind;
    logic               upper;
    logic signed [15:0] meas;

    tracker = new();
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_if.valid     = 1'b0;
    in_if.measured  = '0;
    out_if.ready    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: zero dead band never holds, drive clamps at the limit
    foreach (pts_reset[k]) push_sample(pts_reset[k]);
    settle();

    // dead band edges, forcing both ways, masked drive limit, spare index
    set_reg(CFG_SET_POINT, 16'd0);
    set_reg(CFG_DEAD_BAND, 16'd100);
    set_reg(CFG_BANG_LIMIT, 16'd1000);
    set_reg(CFG_DRIVE_LIMIT, 16'hFFFF);
    set_reg(CFG_GAIN_P, 16'hFFFF);
    set_reg(CFG_GAIN_I, 16'd1);
    set_reg(CFG_GAIN_D, 16'hFFFF);
    set_reg(CFG_IDX_SPARE, 16'hFFFF);
    foreach (pts_band[k]) push_sample(pts_band[k]);
    settle();

    // zero drive limit, widest error
    set_reg(CFG_SET_POINT, 16'h7FFF);
    set_reg(CFG_DEAD_BAND, 16'd0);
    set_reg(CFG_BANG_LIMIT, 16'hFFFF);
    set_reg(CFG_DRIVE_LIMIT, 16'd0);
    set_reg(CFG_GAIN_P, 16'd0);
    set_reg(CFG_GAIN_I, 16'hFFFF);
    set_reg(CFG_GAIN_D, 16'd0);
    foreach (pts_zero[k]) push_sample(pts_zero[k]);
    settle();

    // zero bang limit: any nonzero error forces
    set_reg(CFG_BANG_LIMIT, 16'd0);
    set_reg(CFG_DRIVE_LIMIT, 16'h7FFF);
    push_sample(-16'sd32768);
    push_sample(16'sd32767);
    settle();
    set_reg(CFG_SET_POINT, 16'h8000);
    push_sample(-16'sd32768);
    push_sample(16'sd32767);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      kind = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: set_reg(CFG_SET_POINT, 16'h7FFF);
        1: set_reg(CFG_SET_POINT, 16'h8000);
        2: set_reg(CFG_SET_POINT, 16'd0);
        default: set_reg(CFG_SET_POINT, 16'($urandom));
      endcase
      if (kind == 2) begin
        // windup: far from set point long enough to saturate the integral
        set_reg(CFG_SET_POINT, $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
        set_reg(CFG_DEAD_BAND, 16'd0);
        set_reg(CFG_BANG_LIMIT, 16'hFFFF);
      end else begin
        case ($urandom_range(0, 3))
          0: set_reg(CFG_DEAD_BAND, 16'd0);
          1: set_reg(CFG_DEAD_BAND, 16'($urandom_range(0, 200)));
          2: set_reg(CFG_DEAD_BAND, ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'd0);
          default: set_reg(CFG_DEAD_BAND, 16'($urandom));
        endcase
        case ($urandom_range(0, 3))
          0: set_reg(CFG_BANG_LIMIT, 16'hFFFF);
          1: set_reg(CFG_BANG_LIMIT, 16'($urandom_range(0, 5000)));
          2: set_reg(CFG_BANG_LIMIT, 16'd0);
          default: set_reg(CFG_BANG_LIMIT, 16'($urandom));
        endcase
      end
      case ($urandom_range(0, 3))
        0: set_reg(CFG_DRIVE_LIMIT, 16'h7FFF);
        1: set_reg(CFG_DRIVE_LIMIT, 16'd0);
        default: set_reg(CFG_DRIVE_LIMIT, 16'($urandom));
      endcase
      set_reg(CFG_GAIN_P, pick_gain());
      set_reg(CFG_GAIN_I, pick_gain());
      set_reg(CFG_GAIN_D, pick_gain());

      upper = tracker.cfg.set_point[15];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (kind)
          0: meas = 16'($urandom);
          1: meas = near_set_point(($urandom_range(0, 1) == 0) ? 300 : 6000);
          default: begin
            if (n < 30) begin
              meas = upper ? 16'(32767 - $urandom_range(0, 300))
                           : 16'(-32768 + $urandom_range(0, 300));
            end else begin
              meas = ($urandom_range(0, 3) == 0) ? 16'($urandom) : near_set_point(2000);
            end
          end
        endcase
        push_sample(meas);
      end
      settle();
    end

    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
